// ===== src/sumix_pkg.sv =====
`timescale 1ns / 1ps
package sumix_pkg;
    localparam int NCH = 8;
    localparam logic [3:0] CNT_STEREO = 4'd2;
    localparam logic [3:0] CNT_SURR = 4'd5;
    localparam logic [3:0] CNT_FULL = 4'd8;
    localparam logic [2:0] REG_GF = 3'd0;
    localparam logic [2:0] REG_GR = 3'd1;
    localparam logic [2:0] REG_MAP = 3'd2;
    localparam logic [2:0] REG_SPK = 3'd3;
    localparam logic [2:0] REG_DLY = 3'd4;
    localparam logic [1:0] MODE_STEREO = 2'd0;
    localparam logic [1:0] MODE_SURR = 2'd1;
    localparam logic [1:0] MODE_FULL = 2'd2;
endpackage

// ===== src/sumix_front.sv =====
`timescale 1ns / 1ps
module sumix_front
    import sumix_pkg::*;
#(
    parameter int SB = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [NCH*SB-1:0]   in_data,
    input  logic [3:0]          in_count,
    input  logic                in_valid,
    output logic                in_ready,
    output logic [NCH*SB-1:0]   q_data,
    output logic [1:0]          q_mode,
    output logic                q_valid,
    input  logic                q_ready
);
    logic [NCH*SB-1:0] d0_reg, d1_reg;
    logic [1:0] m0_reg, m1_reg;
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    logic ok, push, pop;
    logic [1:0] mode;

    always_comb
    begin
        mode = MODE_STEREO;
        ok = 1'b1;
        case (in_count)
            CNT_STEREO: mode = MODE_STEREO;
            CNT_SURR: mode = MODE_SURR;
            CNT_FULL: mode = MODE_FULL;
            default: ok = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && ok;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = rd_reg ? d1_reg : d0_reg;
    assign q_mode = rd_reg ? m1_reg : m0_reg;

    always_ff @(posedge clk)
    begin
        if (push && !wr_reg)
        begin
            d0_reg <= in_data;
            m0_reg <= mode;
        end
        if (push && wr_reg)
        begin
            d1_reg <= in_data;
            m1_reg <= mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== src/sumix_back.sv =====
`timescale 1ns / 1ps
module sumix_back
    import sumix_pkg::*;
#(
    parameter int SB = 24,
    parameter int DEPTH = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [NCH*SB-1:0]  q_data,
    input  logic [1:0]         q_mode,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [63:0]        gf,
    input  logic [63:0]        gr,
    input  logic [23:0]        cmap,
    input  logic [3:0]         spk,
    input  logic [12:0]        dly,
    output logic [NCH*SB-1:0]  out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = SB + 18;

    // Stage 1: select sources, read delay lines, clear pass
    // Stage 2: multiply; stage 3: round, saturate, place
    logic [CW-1:0] clr_reg;
    logic clearing;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] len;
    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic st1_reg;
    logic [1:0] mode1_reg;
    logic signed [SB:0] src1_reg [NCH];
    logic signed [SB-1:0] rdl_reg, rdr_reg;
    logic signed [PW-1:0] p2_reg [NCH];
    logic [NCH*SB-1:0] o3_reg;
    logic signed [SB-1:0] lmem [DEPTH];
    logic signed [SB-1:0] rmem [DEPTH];
    logic signed [SB-1:0] x [NCH];
    logic signed [SB-1:0] fl, fr;
    logic stall;
    logic mv1, mv2;

    assign clearing = (clr_reg != CW'(DEPTH));
    assign stall = v3_reg && !out_ready;
    assign q_ready = !stall && !clearing;
    assign adv = q_valid && q_ready;
    assign out_valid = v3_reg;
    assign out_data = o3_reg;

    always_comb
    begin
        for (int i = 0; i < NCH; i++) x[i] = q_data[i*SB +: SB];
        fl = x[cmap[2:0]];
        fr = x[cmap[5:3]];
        len = (dly == 13'd0) ? CW'(1) : (int'(dly) > DEPTH) ? CW'(DEPTH) : CW'(dly);
        pos_next = ({1'b0, pos_reg} + 1'b1 >= (AW+1)'(len)) ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            lmem[clr_reg[AW-1:0]] <= '0;
            rmem[clr_reg[AW-1:0]] <= '0;
        end
        else if (adv && q_mode == MODE_STEREO)
        begin
            rdl_reg <= lmem[pos_reg];
            rdr_reg <= rmem[pos_reg];
            lmem[pos_reg] <= fl;
            rmem[pos_reg] <= fr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= q_mode;
            src1_reg[0] <= {fl[SB-1], fl};
            src1_reg[1] <= {fr[SB-1], fr};
            if (q_mode == MODE_STEREO)
            begin
                src1_reg[2] <= {fl[SB-1], fl} + {fr[SB-1], fr};
                src1_reg[3] <= {fl[SB-1], fl} + {fr[SB-1], fr};
            end
            else
            begin
                src1_reg[2] <= {x[cmap[8:6]][SB-1], x[cmap[8:6]]};
                src1_reg[3] <= {x[cmap[11:9]][SB-1], x[cmap[11:9]]};
            end
            src1_reg[4] <= {x[cmap[14:12]][SB-1], x[cmap[14:12]]};
            src1_reg[5] <= {x[cmap[17:15]][SB-1], x[cmap[17:15]]};
            src1_reg[6] <= (q_mode == MODE_FULL) ? {x[6][SB-1], x[6]} : {fl[SB-1], fl};
            src1_reg[7] <= (q_mode == MODE_FULL) ? {x[7][SB-1], x[7]} : {fr[SB-1], fr};
        end
    end

    always_comb
    begin
        mv1 = v1_reg && !stall;
        mv2 = v2_reg && !stall;
    end

    always_ff @(posedge clk)
    begin
        if (mv1)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                logic signed [SB:0] s;
                logic [15:0] g;
                s = src1_reg[k];
                if (mode1_reg == MODE_STEREO && k == 4) s = {rdl_reg[SB-1], rdl_reg};
                if (mode1_reg == MODE_STEREO && k == 5) s = {rdr_reg[SB-1], rdr_reg};
                g = (k < 4) ? gf[16*(k%4) +: 16] : gr[16*(k%4) +: 16];
                p2_reg[k] <= PW'(s * $signed({1'b0, g}));
            end
            st1_reg <= (mode1_reg == MODE_STEREO);
        end
    end

    function automatic logic signed [SB-1:0] rsat(logic signed [PW-1:0] p, logic s15);
        logic signed [PW-1:0] r;
        begin
            if (s15) r = (p + PW'(1 <<< 14)) >>> 15;
            else r = (p + PW'(1 <<< 13)) >>> 14;
            if (r > PW'((1 <<< (SB-1)) - 1)) rsat = {1'b0, {(SB-1){1'b1}}};
            else if (r < -PW'(1 <<< (SB-1))) rsat = {1'b1, {(SB-1){1'b0}}};
            else rsat = r[SB-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            logic [NCH*SB-1:0] o;
            o = '0;
            o[0 +: SB] = rsat(p2_reg[0], 1'b0);
            o[SB +: SB] = rsat(p2_reg[1], 1'b0);
            if (spk >= 4'd5)
            begin
                o[2*SB +: SB] = rsat(p2_reg[2], st1_reg);
                o[3*SB +: SB] = rsat(p2_reg[3], st1_reg);
                o[4*SB +: SB] = rsat(p2_reg[4], 1'b0);
                o[5*SB +: SB] = rsat(p2_reg[5], 1'b0);
            end
            if (spk >= 4'd8)
            begin
                o[cmap[20:18]*SB +: SB] = rsat(p2_reg[6], 1'b0);
                o[cmap[23:21]*SB +: SB] = rsat(p2_reg[7], 1'b0);
            end
            o3_reg <= o;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            pos_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (adv && q_mode == MODE_STEREO) pos_reg <= pos_next;
            if (!stall)
            begin
                v1_reg <= adv;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end
endmodule

// ===== src/speaker_upmix_with_rear_delay.sv =====
`timescale 1ns / 1ps
// Stereo/5/8-channel to 7.1 upmixer. One frame is accepted per cycle while the
// two-entry queue has room (the back end stalls it while clearing or on
// m_axis_tready). A result passes through the queue, then a three-stage back
// end (source select and delay-line read, gain multiply, round/saturate/place).
// Frames with a channel count other than 2, 5 or 8 are dropped. After reset the
// rear delay lines are cleared before the back end takes the first frame.
// Config: 0 front gains, 1 rear gains, 2 map, 3 speaker count, 4 delay length.
module speaker_upmix_with_rear_delay
    import sumix_pkg::*;
#(
    parameter int DELAY_DEPTH = 4096,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [NCH*SAMPLE_BITS-1:0]  s_axis_tdata,  // in_ch0..in_ch7
    input  logic [3:0]                  s_axis_tuser,  // channel_count
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [NCH*SAMPLE_BITS-1:0]  m_axis_tdata,  // out_ch0..out_ch7
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [63:0]                 cfg_data
);
    logic [63:0] gf_reg, gr_reg;
    logic [23:0] map_reg;
    logic [3:0] spk_reg;
    logic [12:0] dly_reg;
    logic [NCH*SAMPLE_BITS-1:0] q_data;
    logic [1:0] q_mode;
    logic q_valid, q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gf_reg <= 64'h4444444444444444;
            gr_reg <= 64'h4444444444444444;
            map_reg <= 24'd16434824;
            spk_reg <= 4'd2;
            dly_reg <= 13'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GF: gf_reg <= cfg_data;
                REG_GR: gr_reg <= cfg_data;
                REG_MAP: map_reg <= cfg_data[23:0];
                REG_SPK: spk_reg <= cfg_data[3:0];
                REG_DLY: dly_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    sumix_front #(.SB(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_data(s_axis_tdata), .in_count(s_axis_tuser),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .q_data(q_data), .q_mode(q_mode), .q_valid(q_valid), .q_ready(q_ready)
    );

    sumix_back #(.SB(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_data(q_data), .q_mode(q_mode), .q_valid(q_valid), .q_ready(q_ready),
        .gf(gf_reg), .gr(gr_reg), .cmap(map_reg), .spk(spk_reg), .dly(dly_reg),
        .out_data(m_axis_tdata), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
    );
endmodule
